// ===== hw/rtl/bliv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bliv_pkg
// shared constants and types of the limited interface velocity pipeline
// ----------------------------------------------------------------------------
package bliv_pkg;

  localparam int WORD_W         = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam logic [WORD_W-1:0] COURANT_RESET = 32'd32768;

  // load strobes of the four reconstruction stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

// ===== hw/rtl/bliv_recon.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bliv_recon
// four-stage reconstruction of one interface state from a cell value and slope
// ----------------------------------------------------------------------------
module bliv_recon import bliv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  stage_en_t                en,
  input  logic                     is_right,   // 1: u = v - corr, factor 1 + v*r
  input  logic [WORD_W-1:0]        ratio,
  input  logic signed [WORD_W-1:0] vel,
  input  logic signed [WORD_W:0]   slope,
  output logic signed [WORD_W-1:0] state_val,
  output logic                     state_sat
);

  typedef struct packed {
    logic                     hit;
    logic signed [WORD_W-1:0] val;
  } clip_t;

  function automatic clip_t clip_word(input logic signed [65:0] x);
    clip_t res;
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (x > hi) begin
      res.hit = 1'b1;
      res.val = 32'sh7fffffff;
    end else if (x < lo) begin
      res.hit = 1'b1;
      res.val = 32'sh80000000;
    end else begin
      res.hit = 1'b0;
      res.val = x[WORD_W-1:0];
    end
    return res;
  endfunction

  // stage 1: v * r
  logic signed [32:0]       vel_x;
  logic signed [32:0]       ratio_x;
  logic signed [65:0]       prod1_nxt;
  logic signed [65:0]       prod1_r;
  logic signed [WORD_W-1:0] v1_r;
  logic signed [WORD_W:0]   sl1_r;

  assign vel_x     = {vel[WORD_W-1], vel};
  assign ratio_x   = {1'b0, ratio};
  assign prod1_nxt = vel_x * ratio_x;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod1_r <= prod1_nxt;
      v1_r    <= vel;
      sl1_r   <= slope;
    end
  end

  // stage 2: factor 1 -/+ v*r, clipped
  logic signed [65:0]       vr;
  logic signed [65:0]       one_w;
  logic signed [65:0]       fac_wide;
  clip_t                    fac_clip;
  logic signed [WORD_W-1:0] fac2_r;
  logic                     sat2_r;
  logic signed [WORD_W-1:0] v2_r;
  logic signed [WORD_W:0]   sl2_r;

  assign vr       = prod1_r >>> FRAC_BITS;
  assign one_w    = 66'sd1 <<< FRAC_BITS;
  assign fac_wide = is_right ? (one_w + vr) : (one_w - vr);
  assign fac_clip = clip_word(fac_wide);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      fac2_r <= fac_clip.val;
      sat2_r <= fac_clip.hit;
      v2_r   <= v1_r;
      sl2_r  <= sl1_r;
    end
  end

  // stage 3: factor * slope
  logic signed [64:0]       prod3_nxt;
  logic signed [64:0]       prod3_r;
  logic                     sat3_r;
  logic signed [WORD_W-1:0] v3_r;

  assign prod3_nxt = fac2_r * sl2_r;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      prod3_r <= prod3_nxt;
      sat3_r  <= sat2_r;
      v3_r    <= v2_r;
    end
  end

  // stage 4: halve with floor, add to (left) or subtract from (right) cell value, clip
  logic signed [64:0]       corr;
  logic signed [65:0]       corr_x;
  logic signed [65:0]       v3_x;
  logic signed [65:0]       u_wide;
  clip_t                    u_clip;
  logic signed [WORD_W-1:0] u4_r;
  logic                     sat4_r;

  assign corr   = prod3_r >>> (FRAC_BITS + 1);
  assign corr_x = {corr[64], corr};
  assign v3_x   = 66'(v3_r);
  assign u_wide = is_right ? (v3_x - corr_x) : (v3_x + corr_x);
  assign u_clip = clip_word(u_wide);

  always_ff @(posedge clk) begin
    if (en.s4) begin
      u4_r   <= u_clip.val;
      sat4_r <= sat3_r | u_clip.hit;
    end
  end

  assign state_val = u4_r;
  assign state_sat = sat4_r;

endmodule

// ===== hw/rtl/burgers_limited_interface_velocity_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burgers_limited_interface_velocity_top
// minmod-limited reconstruction and burgers riemann solve at one interface
// ----------------------------------------------------------------------------
// an accepted input word passes the five register stages (multiply, clip,
// multiply, add, select) to the output word
// throughput: one word per cycle; stages hold only while the output is refused
// reset (rst_n low, synchronous) empties every stage and loads the courant
// ratio with 0.5 in q16.16; payload registers are not reset
module burgers_limited_interface_velocity_top import bliv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  // configuration: courant ratio, unsigned with FRAC_BITS fraction bits
  input  logic          cfg_wr_en,
  input  logic [31:0]   cfg_wr_data,
  // input stream
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [127:0]  in_tdata,   // vel_far_left, vel_left, vel_right, vel_far_right
  // output stream
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [31:0]   out_tdata,  // interface_velocity
  output logic          out_tuser   // saturated
);

  // courant ratio register
  logic [WORD_W-1:0] courant_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      courant_r <= COURANT_RESET;
    end else if (cfg_wr_en) begin
      courant_r <= cfg_wr_data;
    end
  end

  // unpack the input word
  logic signed [WORD_W-1:0] vel_a;
  logic signed [WORD_W-1:0] vel_b;
  logic signed [WORD_W-1:0] vel_c;
  logic signed [WORD_W-1:0] vel_d;

  assign vel_a = in_tdata[31:0];
  assign vel_b = in_tdata[63:32];
  assign vel_c = in_tdata[95:64];
  assign vel_d = in_tdata[127:96];

  // minmod of two neighbour differences; the differences are exact at 33 bits
  // and a tie gives back the common slope
  function automatic logic signed [WORD_W:0] minmod(
    input logic signed [WORD_W-1:0] p,
    input logic signed [WORD_W-1:0] q,
    input logic signed [WORD_W-1:0] s
  );
    logic signed [WORD_W:0] dl;
    logic signed [WORD_W:0] dr;
    logic [WORD_W:0]        al;
    logic [WORD_W:0]        ar;
    logic signed [WORD_W:0] res;
    dl = 33'(q) - 33'(p);
    dr = 33'(s) - 33'(q);
    al = dl[WORD_W] ? 33'(-dl) : 33'(dl);
    ar = dr[WORD_W] ? 33'(-dr) : 33'(dr);
    if (dl == '0 || dr == '0 || dl[WORD_W] != dr[WORD_W]) begin
      res = '0;
    end else if (al <= ar) begin
      res = dl;
    end else begin
      res = dr;
    end
    return res;
  endfunction

  logic signed [WORD_W:0] slope_l;
  logic signed [WORD_W:0] slope_r;

  assign slope_l = minmod(vel_a, vel_b, vel_c);
  assign slope_r = minmod(vel_b, vel_c, vel_d);

  // pipeline control: a stage takes a new word when it is empty or its
  // successor moves on, so bubbles collapse and a stall drops nothing
  logic      v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic      v1_nxt, v2_nxt, v3_nxt, v4_nxt, out_valid_nxt;
  logic      rdy1, rdy2, rdy3, rdy4, rdy5;
  stage_en_t stage_en;
  logic      out_load;

  assign rdy5 = !out_valid_r || out_tready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign stage_en.s1 = rdy1 && in_tvalid;
  assign stage_en.s2 = rdy2 && v1_r;
  assign stage_en.s3 = rdy3 && v2_r;
  assign stage_en.s4 = rdy4 && v3_r;
  assign out_load    = rdy5 && v4_r;

  assign v1_nxt        = rdy1 ? in_tvalid : v1_r;
  assign v2_nxt        = rdy2 ? v1_r      : v2_r;
  assign v3_nxt        = rdy3 ? v2_r      : v3_r;
  assign v4_nxt        = rdy4 ? v3_r      : v4_r;
  assign out_valid_nxt = rdy5 ? v4_r      : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      v4_r        <= v4_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // left state uL = b + 0.5*(1 - b*r)*sL, right state uR = c - 0.5*(1 + c*r)*sR
  logic signed [WORD_W-1:0] state_l;
  logic signed [WORD_W-1:0] state_r;
  logic                     sat_l;
  logic                     sat_r;

  bliv_recon #(
    .FRAC_BITS (FRAC_BITS)
  ) u_recon_l (
    .clk       (clk),
    .en        (stage_en),
    .is_right  (1'b0),
    .ratio     (courant_r),
    .vel       (vel_b),
    .slope     (slope_l),
    .state_val (state_l),
    .state_sat (sat_l)
  );

  bliv_recon #(
    .FRAC_BITS (FRAC_BITS)
  ) u_recon_r (
    .clk       (clk),
    .en        (stage_en),
    .is_right  (1'b1),
    .ratio     (courant_r),
    .vel       (vel_c),
    .slope     (slope_r),
    .state_val (state_r),
    .state_sat (sat_r)
  );

  // riemann solve: shock takes the sign of the mean, otherwise the
  // rarefaction rule, with zero at a sonic point
  logic signed [WORD_W:0]   state_sum;
  logic signed [WORD_W-1:0] riemann_nxt;
  logic signed [WORD_W-1:0] result_r;
  logic                     sat_out_r;

  assign state_sum = 33'(state_l) + 33'(state_r);

  always_comb begin
    if (state_l > state_r) begin
      if (state_sum > 0) begin
        riemann_nxt = state_l;
      end else if (state_sum < 0) begin
        riemann_nxt = state_r;
      end else begin
        riemann_nxt = '0;
      end
    end else begin
      if (state_l > 0) begin
        riemann_nxt = state_l;
      end else if (state_r < 0) begin
        riemann_nxt = state_r;
      end else begin
        riemann_nxt = '0;
      end
    end
  end

  // output register: holds while the consumer refuses the word
  always_ff @(posedge clk) begin
    if (out_load) begin
      result_r  <= riemann_nxt;
      sat_out_r <= sat_l | sat_r;
    end
  end

  assign in_tready  = rdy1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = result_r;
  assign out_tuser  = sat_out_r;

endmodule

// ===== hw/rtl/bliv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bliv_checker
// port-level checks of the interface velocity pipeline
// ----------------------------------------------------------------------------
module bliv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // a refused output word stays and holds its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // input backpressure only ever comes from a refused output word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  // with the output free-flowing the input is always taken
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready && !out_tvalid |-> in_tready)
    else $error("input refused with an empty output");

endmodule

bind burgers_limited_interface_velocity_top bliv_checker u_bliv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
